// File: rtl/gds_pkg.sv
package gds_pkg;

    // Phase codes of the drive sequencer.
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_FWD         = 4'd1;
    localparam logic [3:0] PH_SETTLE_BACK = 4'd2;
    localparam logic [3:0] PH_SETTLE_ADV  = 4'd3;
    localparam logic [3:0] PH_BACK        = 4'd4;
    localparam logic [3:0] PH_TURN        = 4'd5;
    localparam logic [3:0] PH_ADVANCE     = 4'd6;
    localparam logic [3:0] PH_BUMP_BACK   = 4'd7;
    localparam logic [3:0] PH_BUMP_TURN   = 4'd8;

    // Event codes reported on the word that detects the event.
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_FL_LOW    = 4'd1;
    localparam logic [3:0] EV_L_LOW     = 4'd2;
    localparam logic [3:0] EV_FR_DROP   = 4'd3;
    localparam logic [3:0] EV_R_DROP    = 4'd4;
    localparam logic [3:0] EV_FL_HIGH   = 4'd5;
    localparam logic [3:0] EV_L_HIGH    = 4'd6;
    localparam logic [3:0] EV_FR_HIGH   = 4'd7;
    localparam logic [3:0] EV_R_HIGH    = 4'd8;
    localparam logic [3:0] EV_BUMP_L    = 4'd9;
    localparam logic [3:0] EV_BUMP_R    = 4'd10;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_CROSS_LINES    = 3'd0;
    localparam logic [2:0] REG_DRIVE_SPEED    = 3'd1;
    localparam logic [2:0] REG_TURN_SPEED     = 3'd2;
    localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_CLIFF_BACKUP   = 3'd5;
    localparam logic [2:0] REG_BUMP_BACKUP    = 3'd6;
    localparam logic [2:0] REG_LINE_ADVANCE   = 3'd7;

    // Turn angles in degrees.
    localparam logic [6:0] DEG_WIDE   = 7'd125;
    localparam logic [6:0] DEG_RIGHT  = 7'd90;
    localparam logic [6:0] DEG_LINE_A = 7'd80;
    localparam logic [6:0] DEG_LINE_B = 7'd45;
    localparam logic [6:0] DEG_BUMP   = 7'd25;

    localparam logic [8:0] SPEED_MAX = 9'd500;

    typedef struct packed {
        logic        cross_lines;
        logic [8:0]  drive_speed;
        logic [8:0]  turn_speed;
        logic [11:0] low_threshold;
        logic [11:0] high_threshold;
        logic [9:0]  cliff_backup;
        logic [9:0]  bump_backup;
        logic [11:0] line_advance;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [14:0] target_distance;
        logic [15:0] distance_delta;
        logic [15:0] angle_delta;
        logic        bump_left;
        logic        bump_right;
        logic [11:0] front_left_signal;
        logic [11:0] left_signal;
        logic [11:0] front_right_signal;
        logic [11:0] right_signal;
        logic        front_right_drop;
        logic        right_drop;
    } t_item;

    typedef struct packed {
        logic [3:0]  phase;
        logic [14:0] phase_goal;
        logic [6:0]  turn_goal;
        logic        turn_cw;
        logic        crossed;
        logic        left_bump;
        logic        right_bump;
    } t_state;

    typedef struct packed {
        logic [9:0] left_wheel;
        logic [9:0] right_wheel;
        logic       busy_res;
        logic [3:0] event_code;
        logic       line_crossed;
        logic       bumped_left_seen;
        logic       bumped_right_seen;
    } t_result;

endpackage

// File: rtl/guarded_drive_sequencer.sv
// Guarded drive sequencer. Every accepted word on the input stream yields exactly one result
// word: the word is captured in an input register when accepted, the phase logic and
// saturating odometer add work on the held word, and the result is registered in the output
// register once the output is empty or its word is taken. A new word is accepted in every
// cycle unless the output stalls; while the output word waits, one further word is still
// taken into the input register. Input tuser is the mode bit (0 sensor tick, 1 start move).
// Users must write configuration over the APB port while the stream is quiet; not enforced here.
module guarded_drive_sequencer
    import gds_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [14:0] target_distance, [30:15] distance_delta, [46:31] angle_delta,
    // [47] bump_left, [48] bump_right, [60:49] front_left_signal, [72:61] left_signal,
    // [84:73] front_right_signal, [96:85] right_signal, [97] front_right_drop,
    // [98] right_drop, [103:99] zero
    input  logic [103:0] i_s_axis_tdata,
    // [0] mode
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [9:0] left_wheel, [19:10] right_wheel, [20] busy_res, [24:21] event_code,
    // [25] line_crossed, [26] bumped_left_seen, [27] bumped_right_seen, [31:28] zero
    output logic [31:0]  o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_cfg                 w_cfg;
    t_item                r_in;
    logic                 r_in_valid;
    t_result              r_out;
    logic                 r_out_valid;
    t_state               r_state;
    t_state               n_state;
    logic [SUM_WIDTH-1:0] r_sum;
    logic [SUM_WIDTH-1:0] n_sum;
    t_result              n_res;
    logic                 w_advance;
    logic                 w_in_acc;

    gds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gds_step #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_step (
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .i_state (r_state),
        .i_sum   (r_sum),
        .o_state (n_state),
        .o_sum   (n_sum),
        .o_res   (n_res)
    );

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.mode               <= i_s_axis_tuser;
            r_in.target_distance    <= i_s_axis_tdata[14:0];
            r_in.distance_delta     <= i_s_axis_tdata[30:15];
            r_in.angle_delta        <= i_s_axis_tdata[46:31];
            r_in.bump_left          <= i_s_axis_tdata[47];
            r_in.bump_right         <= i_s_axis_tdata[48];
            r_in.front_left_signal  <= i_s_axis_tdata[60:49];
            r_in.left_signal        <= i_s_axis_tdata[72:61];
            r_in.front_right_signal <= i_s_axis_tdata[84:73];
            r_in.right_signal       <= i_s_axis_tdata[96:85];
            r_in.front_right_drop   <= i_s_axis_tdata[97];
            r_in.right_drop         <= i_s_axis_tdata[98];
        end
    end

    // Sequencer state moves only when the held word passes into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.phase_goal <= 15'd0;
            r_state.turn_goal  <= 7'd0;
            r_state.turn_cw    <= 1'b0;
            r_state.crossed    <= 1'b0;
            r_state.left_bump  <= 1'b0;
            r_state.right_bump <= 1'b0;
            r_sum              <= '0;
        end else if (w_advance && r_in_valid) begin
            r_state <= n_state;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out.bumped_right_seen, r_out.bumped_left_seen,
                              r_out.line_crossed, r_out.event_code, r_out.busy_res,
                              r_out.right_wheel, r_out.left_wheel};

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !w_in_acc)
        else $error("input register overwritten while stalled");

    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid) |=> (r_out.busy_res == (r_state.phase != PH_IDLE)))
        else $error("busy flag does not match sequencer phase");

    a_idle_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |->
            (r_out.left_wheel == 10'd0 && r_out.right_wheel == 10'd0))
        else $error("wheels commanded while idle");

    a_event_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code != EV_NONE) |-> r_out.busy_res)
        else $error("event reported without a recovery in progress");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_state.crossed) && !$fell(r_state.left_bump) && !$fell(r_state.right_bump))
        else $error("sticky flag cleared outside reset");
`endif

endmodule

// File: rtl/gds_regs.sv
module gds_regs
    import gds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cross_lines    <= 1'b0;
            r_cfg.drive_speed    <= 9'd200;
            r_cfg.turn_speed     <= 9'd50;
            r_cfg.low_threshold  <= 12'd1000;
            r_cfg.high_threshold <= 12'd2700;
            r_cfg.cliff_backup   <= 10'd25;
            r_cfg.bump_backup    <= 10'd50;
            r_cfg.line_advance   <= 12'd400;
        end else if (w_wr) begin
            case (w_idx)
                REG_CROSS_LINES:    r_cfg.cross_lines    <= pwdata[0];
                REG_DRIVE_SPEED:    r_cfg.drive_speed    <= pwdata[8:0];
                REG_TURN_SPEED:     r_cfg.turn_speed     <= pwdata[8:0];
                REG_LOW_THRESHOLD:  r_cfg.low_threshold  <= pwdata[11:0];
                REG_HIGH_THRESHOLD: r_cfg.high_threshold <= pwdata[11:0];
                REG_CLIFF_BACKUP:   r_cfg.cliff_backup   <= pwdata[9:0];
                REG_BUMP_BACKUP:    r_cfg.bump_backup    <= pwdata[9:0];
                REG_LINE_ADVANCE:   r_cfg.line_advance   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CROSS_LINES:    prdata = {31'd0, r_cfg.cross_lines};
            REG_DRIVE_SPEED:    prdata = {23'd0, r_cfg.drive_speed};
            REG_TURN_SPEED:     prdata = {23'd0, r_cfg.turn_speed};
            REG_LOW_THRESHOLD:  prdata = {20'd0, r_cfg.low_threshold};
            REG_HIGH_THRESHOLD: prdata = {20'd0, r_cfg.high_threshold};
            REG_CLIFF_BACKUP:   prdata = {22'd0, r_cfg.cliff_backup};
            REG_BUMP_BACKUP:    prdata = {22'd0, r_cfg.bump_backup};
            REG_LINE_ADVANCE:   prdata = {20'd0, r_cfg.line_advance};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/gds_step.sv
module gds_step
    import gds_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  t_cfg                  i_cfg,
    input  t_item                 i_item,
    input  t_state                i_state,
    input  logic [SUM_WIDTH-1:0]  i_sum,
    output t_state                o_state,
    output logic [SUM_WIDTH-1:0]  o_sum,
    output t_result               o_res
);

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                     input logic [15:0] d);
        logic [SUM_WIDTH:0] s;
        s = {a[SUM_WIDTH-1], a} + {{(SUM_WIDTH-15){d[15]}}, d};
        if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
            sat_add = s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sat_add = s[SUM_WIDTH-1:0];
        end
    endfunction

    logic [SUM_WIDTH-1:0]        w_sum_d;
    logic [SUM_WIDTH-1:0]        w_sum_a;
    logic signed [SUM_WIDTH-1:0] w_goal_s;
    logic signed [SUM_WIDTH-1:0] w_tg_s;
    logic signed [SUM_WIDTH-1:0] w_tg_neg;
    logic [SUM_WIDTH:0]          w_mag;
    logic                        w_fwd_done;
    logic                        w_back_done;
    logic                        w_turn_done;
    logic [3:0]                  w_code;
    logic [3:0]                  w_phase;
    logic [3:0]                  n_code;
    logic [8:0]                  w_drive;
    logic [8:0]                  w_turn;
    logic [9:0]                  w_drive_w;
    logic [9:0]                  w_turn_w;
    logic [14:0]                 w_back_goal;
    logic                        w_back_bump;
    logic                        w_back_go;

    assign w_phase = i_state.phase;

    assign w_sum_d  = sat_add(i_sum, i_item.distance_delta);
    assign w_sum_a  = sat_add(i_sum, i_item.angle_delta);
    assign w_goal_s = $signed({{(SUM_WIDTH-15){1'b0}}, i_state.phase_goal});
    assign w_tg_s   = $signed({{(SUM_WIDTH-7){1'b0}}, i_state.turn_goal});
    assign w_tg_neg = -w_tg_s;
    assign w_mag    = w_sum_d[SUM_WIDTH-1] ? -{1'b1, w_sum_d} : {1'b0, w_sum_d};

    assign w_fwd_done  = $signed(w_sum_d) >= w_goal_s;
    assign w_back_done = w_mag >= {{(SUM_WIDTH-14){1'b0}}, i_state.phase_goal};
    assign w_turn_done = i_state.turn_cw ? ($signed(w_sum_a) <= w_tg_neg)
                                         : ($signed(w_sum_a) >= w_tg_s);

    // Floor sensor priority, checked only when no bumper is pressed.
    always_comb begin
        if (i_item.front_left_signal < i_cfg.low_threshold)        w_code = EV_FL_LOW;
        else if (i_item.left_signal < i_cfg.low_threshold)         w_code = EV_L_LOW;
        else if (i_item.front_right_drop)                          w_code = EV_FR_DROP;
        else if (i_item.right_drop)                                w_code = EV_R_DROP;
        else if (i_item.front_left_signal > i_cfg.high_threshold)  w_code = EV_FL_HIGH;
        else if (i_item.left_signal > i_cfg.high_threshold)        w_code = EV_L_HIGH;
        else if (i_item.front_right_signal > i_cfg.high_threshold) w_code = EV_FR_HIGH;
        else if (i_item.right_signal > i_cfg.high_threshold)       w_code = EV_R_HIGH;
        else                                                       w_code = EV_NONE;
    end

    always_comb begin
        o_state     = i_state;
        o_sum       = i_sum;
        n_code      = EV_NONE;
        w_back_go   = 1'b0;
        w_back_goal = 15'd0;
        w_back_bump = 1'b0;
        if (i_item.mode) begin
            o_sum              = '0;
            o_state.phase_goal = i_item.target_distance;
            o_state.phase      = (i_item.target_distance == 15'd0) ? PH_IDLE : PH_FWD;
        end else begin
            case (w_phase)
                PH_FWD: begin
                    o_sum = w_sum_d;
                    if (i_item.bump_left) begin
                        n_code            = EV_BUMP_L;
                        w_back_go         = 1'b1;
                        w_back_goal       = {5'd0, i_cfg.bump_backup};
                        w_back_bump       = 1'b1;
                        o_state.turn_goal = DEG_BUMP;
                        o_state.turn_cw   = 1'b1;
                    end else if (i_item.bump_right) begin
                        n_code            = EV_BUMP_R;
                        w_back_go         = 1'b1;
                        w_back_goal       = {5'd0, i_cfg.bump_backup};
                        w_back_bump       = 1'b1;
                        o_state.turn_goal = DEG_BUMP;
                        o_state.turn_cw   = 1'b0;
                    end else if (w_code == EV_NONE) begin
                        if (w_fwd_done) o_state.phase = PH_IDLE;
                    end else if (w_code <= EV_R_DROP) begin
                        n_code            = w_code;
                        o_state.turn_goal = w_code[0] ? DEG_WIDE : DEG_RIGHT;
                        o_state.turn_cw   = (w_code <= EV_L_LOW);
                        o_state.phase     = PH_SETTLE_BACK;
                    end else if (i_cfg.cross_lines) begin
                        n_code        = w_code;
                        o_state.phase = PH_SETTLE_ADV;
                    end else begin
                        n_code            = w_code;
                        o_state.turn_goal = w_code[0] ? DEG_LINE_A : DEG_LINE_B;
                        o_state.turn_cw   = (w_code <= EV_L_HIGH);
                        o_state.phase     = PH_SETTLE_BACK;
                    end
                end
                PH_SETTLE_BACK: begin
                    w_back_go   = 1'b1;
                    w_back_goal = {5'd0, i_cfg.cliff_backup};
                    w_back_bump = 1'b0;
                end
                PH_SETTLE_ADV: begin
                    o_sum              = '0;
                    o_state.phase_goal = {3'd0, i_cfg.line_advance};
                    if (i_cfg.line_advance == 12'd0) begin
                        o_state.crossed = 1'b1;
                        o_state.phase   = PH_IDLE;
                    end else begin
                        o_state.phase = PH_ADVANCE;
                    end
                end
                PH_BACK, PH_BUMP_BACK: begin
                    o_sum = w_sum_d;
                    if (w_back_done) begin
                        o_sum         = '0;
                        o_state.phase = (w_phase == PH_BUMP_BACK) ? PH_BUMP_TURN
                                                                  : PH_TURN;
                    end
                end
                PH_TURN, PH_BUMP_TURN: begin
                    o_sum = w_sum_a;
                    if (w_turn_done) begin
                        if (w_phase == PH_BUMP_TURN) begin
                            if (i_state.turn_cw) o_state.left_bump  = 1'b1;
                            else                 o_state.right_bump = 1'b1;
                        end
                        o_state.phase = PH_IDLE;
                    end
                end
                PH_ADVANCE: begin
                    o_sum = w_sum_d;
                    if (w_fwd_done) begin
                        o_state.crossed = 1'b1;
                        o_state.phase   = PH_IDLE;
                    end
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase

            // Start of a back-up; a zero distance goes straight on to the turn.
            if (w_back_go) begin
                o_sum              = '0;
                o_state.phase_goal = w_back_goal;
                if (w_back_goal == 15'd0) begin
                    o_state.phase = w_back_bump ? PH_BUMP_TURN : PH_TURN;
                end else begin
                    o_state.phase = w_back_bump ? PH_BUMP_BACK : PH_BACK;
                end
            end
        end
    end

    assign w_drive   = (i_cfg.drive_speed > SPEED_MAX) ? SPEED_MAX : i_cfg.drive_speed;
    assign w_turn    = (i_cfg.turn_speed > SPEED_MAX) ? SPEED_MAX : i_cfg.turn_speed;
    assign w_drive_w = {1'b0, w_drive};
    assign w_turn_w  = {1'b0, w_turn};

    always_comb begin
        o_res.left_wheel  = 10'd0;
        o_res.right_wheel = 10'd0;
        case (o_state.phase)
            PH_FWD, PH_ADVANCE: begin
                o_res.left_wheel  = w_drive_w;
                o_res.right_wheel = w_drive_w;
            end
            PH_BACK, PH_BUMP_BACK: begin
                o_res.left_wheel  = -w_drive_w;
                o_res.right_wheel = -w_drive_w;
            end
            PH_TURN, PH_BUMP_TURN: begin
                o_res.left_wheel  = o_state.turn_cw ? -w_turn_w : w_turn_w;
                o_res.right_wheel = o_state.turn_cw ? w_turn_w : -w_turn_w;
            end
            default: ;
        endcase
        o_res.busy_res          = (o_state.phase != PH_IDLE);
        o_res.event_code        = n_code;
        o_res.line_crossed      = o_state.crossed;
        o_res.bumped_left_seen  = o_state.left_bump;
        o_res.bumped_right_seen = o_state.right_bump;
    end

endmodule
